// ----- src/ccl_pkg.sv -----
// ============================================================================
// ccl_pkg
// Shared types, constants and the CRC-32C word-fold function for the
// candidate list checker.
// ============================================================================
package ccl_pkg;

    localparam int NUM_CANDIDATES_DEF = 32;
    localparam int CAND_W             = 5;
    localparam int WORD_W             = 32;
    localparam int CMD_W              = 2;
    localparam int CAND_SPAN          = 2 ** CAND_W;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'h82F63B78;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA   = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef logic [WORD_W-1:0] t_word;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        t_cmd              cmd;
        logic              in_range;
        logic [CAND_W-1:0] cand;
        t_word             word;
    } t_item;

    typedef struct packed {
        logic [CAND_W-1:0] match_index;
        logic              match_found;
        t_word             crc_value;
    } t_result;

    typedef logic [WORD_W-1:0][WORD_W-1:0] t_cols;

    // Column i holds the 32-step reflected fold of a word with only bit i set.
    function automatic t_cols f_build_cols();
        t_cols cols;
        t_word r;
        for (int i = 0; i < WORD_W; i++) begin
            r = t_word'(1) << i;
            for (int b = 0; b < WORD_W; b++) begin
                if (r[0]) begin
                    r = (r >> 1) ^ CRC_POLY;
                end else begin
                    r = r >> 1;
                end
            end
            cols[i] = r;
        end
        return cols;
    endfunction

    localparam t_cols CRC_COLS = f_build_cols();

    // The fold is linear, so the whole word step is one XOR matrix.
    function automatic t_word f_crc_fold(input t_word crc, input t_word word);
        t_word r;
        t_word acc;
        r   = crc ^ word;
        acc = '0;
        for (int i = 0; i < WORD_W; i++) begin
            acc = acc ^ (CRC_COLS[i] & {WORD_W{r[i]}});
        end
        return acc;
    endfunction

endpackage

// ----- src/ccl_front.sv -----
// ============================================================================
// ccl_front
// Input stage: takes stream beats, decodes the command and checks the
// candidate index against the configured number of candidates.
// ============================================================================
module ccl_front import ccl_pkg::*; #(
    parameter int NUM_CANDIDATES = NUM_CANDIDATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [4:0] candidate, [36:5] data_word, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        o_item_valid,
    input  logic        i_item_ready,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;
    logic  [CAND_W-1:0] w_cand;

    assign s_axis_tready = !r_valid || i_item_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cand        = s_axis_tdata[CAND_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd      <= t_cmd'(s_axis_tuser);
            r_item.cand     <= w_cand;
            r_item.word     <= s_axis_tdata[CAND_W +: WORD_W];
            r_item.in_range <= (32'(w_cand) < 32'(NUM_CANDIDATES));
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ----- src/ccl_queue.sv -----
// ============================================================================
// ccl_queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module ccl_queue import ccl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above its depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count missed a push");

endmodule

// ----- src/ccl_back.sv -----
// ============================================================================
// ccl_back
// Execution stage: holds per-candidate CRCs and match marks, drives the result
// register, runs one command per cycle unless a finish or read finds it full.
// ============================================================================
module ccl_back import ccl_pkg::*; #(
    parameter int NUM_CANDIDATES = NUM_CANDIDATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] crc_value, [32] match_found,
                                        // [37:33] match_index, rest zero
);

    // Only indexes the 5-bit candidate field can reach need storage.
    localparam int NUM_SLOTS = (NUM_CANDIDATES < CAND_SPAN) ? NUM_CANDIDATES : CAND_SPAN;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_word                r_crc [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_live;
    logic [NUM_SLOTS-1:0] r_mark;
    logic                 r_out_valid;
    t_result              r_out;

    logic [NUM_SLOTS-1:0] n_live;
    logic [NUM_SLOTS-1:0] n_mark;
    logic                 n_out_valid;
    t_result              n_out;

    logic [IDX_W-1:0]     w_idx;
    t_word                w_cur_crc;
    t_word                w_fold;
    logic                 w_needs_out;
    logic                 w_slot_free;
    logic                 w_exec;
    logic                 w_found;
    logic [CAND_W-1:0]    w_found_idx;

    assign w_idx       = i_item.cand[IDX_W-1:0];
    assign w_needs_out = (i_item.cmd == CMD_FINISH) || (i_item.cmd == CMD_READ);
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign o_ready     = !w_needs_out || w_slot_free;
    assign w_exec      = i_valid && o_ready;

    // An entry without its live bit reads as a cleared CRC.
    assign w_cur_crc = (i_item.in_range && r_live[w_idx]) ? r_crc[w_idx] : '0;
    assign w_fold    = f_crc_fold(w_cur_crc, i_item.word);

    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mark[i]) begin
                w_found     = 1'b1;
                w_found_idx = CAND_W'(i);
            end
        end
    end

    always_comb begin
        n_live      = r_live;
        n_mark      = r_mark;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        if (w_exec) begin
            unique case (i_item.cmd)
                CMD_DATA: begin
                    if (i_item.in_range) begin
                        n_live[w_idx] = 1'b1;
                    end
                end
                CMD_CHECK: begin
                    if (i_item.in_range) begin
                        n_mark[w_idx] = (w_cur_crc == i_item.word);
                    end
                end
                CMD_FINISH: begin
                    n_live      = '0;
                    n_mark      = '0;
                    n_out_valid = 1'b1;
                    n_out       = '{match_index: w_found_idx, match_found: w_found,
                                    crc_value: '0};
                end
                CMD_READ: begin
                    n_out_valid = 1'b1;
                    n_out       = '{match_index: '0, match_found: 1'b0,
                                    crc_value: w_cur_crc};
                    if (i_item.in_range) begin
                        n_live[w_idx] = 1'b0;
                        n_mark[w_idx] = 1'b0;
                    end
                end
                default: begin
                    n_out_valid = r_out_valid && !m_axis_tready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_live      <= n_live;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_exec && (i_item.cmd == CMD_DATA) && i_item.in_range) begin
            r_crc[w_idx] <= w_fold;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.match_index, r_out.match_found, r_out.crc_value};

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_item.cmd == CMD_FINISH) |=> (r_live == '0 && r_mark == '0))
        else $error("finish left candidate state behind");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_item.cmd == CMD_READ && i_item.in_range)
            |=> (!r_live[$past(w_idx)] && !r_mark[$past(w_idx)]))
        else $error("read did not clear its candidate");

    a_data_sets_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_item.cmd == CMD_DATA && i_item.in_range) |=> r_live[$past(w_idx)])
        else $error("data word did not mark its candidate live");

    a_found_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.match_found) |-> (r_out.crc_value == '0))
        else $error("finish result carries a CRC value");

endmodule

// ----- src/crc32c_list_checker.sv -----
// ============================================================================
// crc32c_list_checker
// Running CRC-32C (reflected 0x82F63B78, start zero, no final inversion)
// per candidate frame with checksum matching and lowest-match reporting.
// ============================================================================
//
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   candidate[4:0], data_word[36:5]            command[1:0]
// m_axis    out  crc_value[31:0], match_found[32],          -
//                match_index[37:33]
//
// One beat per cycle is accepted and executed while no finish or read waits
// on a full result register. A result beat passes through the front register,
// the queue and the result register before it is offered on m_axis.
// The one-beat-per-cycle rate is set by the execution stage, where one 32-bit
// XOR matrix folds a whole word into the selected candidate's CRC.
// Reset is synchronous and active low and clears all candidate state at once.
// A stalled m_axis only blocks a finish or read command once the result
// register is occupied; data and checksum beats ahead of it still execute,
// and beats behind it wait in the queue and front register until they fill.
//
module crc32c_list_checker import ccl_pkg::*; #(
    parameter int NUM_CANDIDATES = NUM_CANDIDATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [4:0] candidate, [36:5] data_word, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] crc_value, [32] match_found,
                                        // [37:33] match_index, rest zero
);

    logic  w_front_valid;
    logic  w_front_ready;
    t_item w_front_item;
    logic  w_queue_valid;
    logic  w_back_ready;
    t_item w_queue_item;

    ccl_front #(
        .NUM_CANDIDATES(NUM_CANDIDATES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_valid  (w_front_valid),
        .i_item_ready  (w_front_ready),
        .o_item        (w_front_item)
    );

    ccl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .o_ready (w_front_ready),
        .i_item  (w_front_item),
        .o_valid (w_queue_valid),
        .i_pop   (w_back_ready),
        .o_item  (w_queue_item)
    );

    ccl_back #(
        .NUM_CANDIDATES(NUM_CANDIDATES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_queue_valid),
        .o_ready       (w_back_ready),
        .i_item        (w_queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- tb/tb_crc32c_list_checker.sv -----
// ============================================================================
// tb_crc32c_list_checker
// Self-checking bench for the per-candidate CRC-32C checker. Stimulus starts
// with directed beats for reset state, matching and failing checksums, data
// after a checksum, lowest-match selection and read clearing. Random batches
// of well-formed frames follow, mixed with noise beats. A scoreboard class
// predicts every result beat and compares it field by field.
// ============================================================================
module tb_crc32c_list_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import ccl_pkg::*;

    localparam int NUM_CAND    = 32;
    localparam int ITEM_TARGET = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    // Reference behavior of the checker; expectations are queued in order.
    class crc_scoreboard;
        t_word   crc_state [NUM_CAND];
        bit      mark [NUM_CAND];
        t_result expected_q [$];
        int      err_count;
        int      checked;
        int      match_reports;
        int      read_reports;

        function new();
            clear_all();
        endfunction

        function void clear_all();
            foreach (crc_state[i]) begin
                crc_state[i] = '0;
                mark[i]      = 1'b0;
            end
        endfunction

        // One whole word folded in, least significant bit first.
        static function t_word fold_word(t_word crc, t_word word);
            t_word r;
            r = crc ^ word;
            for (int b = 0; b < WORD_W; b++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_cmd cmd, logic [CAND_W-1:0] cand, t_word word);
            t_result res;
            bit      in_range;
            in_range = (cand < NUM_CAND);
            res      = '0;
            case (cmd)
                CMD_DATA: begin
                    if (in_range) crc_state[cand] = fold_word(crc_state[cand], word);
                end
                CMD_CHECK: begin
                    if (in_range) mark[cand] = (crc_state[cand] == word);
                end
                CMD_FINISH: begin
                    for (int i = 0; i < NUM_CAND; i++) begin
                        if (mark[i] && !res.match_found) begin
                            res.match_found = 1'b1;
                            res.match_index = CAND_W'(i);
                        end
                    end
                    if (res.match_found) match_reports++;
                    clear_all();
                    expected_q.push_back(res);
                end
                default: begin
                    if (in_range) begin
                        res.crc_value   = crc_state[cand];
                        crc_state[cand] = '0;
                        mark[cand]      = 1'b0;
                    end
                    read_reports++;
                    expected_q.push_back(res);
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
            $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h",
                     $realtime, what, got_v, exp_v);
            err_count++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", got.crc_value, '0);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.crc_value !== exp.crc_value)
                report_mismatch("crc_value", got.crc_value, exp.crc_value);
            if (got.match_found !== exp.match_found)
                report_mismatch("match_found", 32'(got.match_found), 32'(exp.match_found));
            if (got.match_index !== exp.match_index)
                report_mismatch("match_index", 32'(got.match_index), 32'(exp.match_index));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [4:0] candidate, [36:5] data_word
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [31:0] crc_value, [32] match_found,
                                       // [37:33] match_index

    crc_scoreboard sb = new();

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int items_sent  = 0;
    int cycle_count = 0;

    crc32c_list_checker #(
        .NUM_CANDIDATES(NUM_CAND)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending());
            $display("tb_crc32c_list_checker failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(t_result'(m_axis_tdata[37:0]));
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. The valid
    // line stays high so that the next beat can follow without a gap.
    task send_item(t_cmd cmd, logic [CAND_W-1:0] cand, t_word word);
        while (!no_idle && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, word, cand};
        s_axis_tuser  <= cmd;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_input(cmd, cand, word);
        items_sent++;
    endtask

    task send_checksum(logic [CAND_W-1:0] cand, bit good);
        send_item(CMD_CHECK, cand, good ? sb.crc_state[cand] : sb.crc_state[cand] ^ 32'h1);
    endtask

    // A batch of well-formed frames with random content, closed by a
    // finish or by reads of the candidates involved.
    task send_batch();
        logic [CAND_W-1:0] cand;
        logic [CAND_W-1:0] used [$];
        int                nframes;
        int                nwords;
        int                roll;
        nframes = $urandom_range(4, 1);
        for (int f = 0; f < nframes; f++) begin
            cand   = CAND_W'($urandom_range(NUM_CAND - 1));
            nwords = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
            used.push_back(cand);
            for (int w = 0; w < nwords; w++) send_item(CMD_DATA, cand, $urandom());
            roll = $urandom_range(99);
            if (roll < 60) begin
                send_checksum(cand, 1'b1);
            end else if (roll < 80) begin
                send_item(CMD_CHECK, cand, sb.crc_state[cand] ^ (t_word'(1) << $urandom_range(31)));
            end else begin
                send_item(CMD_CHECK, cand, $urandom());
            end
            if ($urandom_range(99) < 15) send_item(CMD_DATA, cand, $urandom());
        end
        if ($urandom_range(99) < 80) begin
            send_item(CMD_FINISH, CAND_W'($urandom_range(NUM_CAND - 1)), $urandom());
        end else begin
            foreach (used[i]) send_item(CMD_READ, used[i], $urandom());
        end
    endtask

    initial begin
        t_word w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A fresh candidate has CRC zero, so a zero checksum
        // word already matches.
        send_item(CMD_FINISH, 5'd0, 32'h0);
        send_item(CMD_READ, 5'd0, 32'hFFFF_FFFF);
        send_item(CMD_CHECK, 5'd9, 32'h0);
        send_item(CMD_DATA, 5'd31, 32'hFFFF_FFFF);
        send_item(CMD_READ, 5'd31, 32'h0);
        send_item(CMD_FINISH, 5'd31, 32'h0);
        send_item(CMD_DATA, 5'd5, 32'hA5A5_5A5A);
        send_item(CMD_DATA, 5'd5, 32'h0000_0001);
        send_checksum(5'd5, 1'b1);
        send_item(CMD_DATA, 5'd3, 32'h8000_0000);
        send_checksum(5'd3, 1'b1);
        // More data after a checksum advances the CRC but keeps the mark.
        send_item(CMD_DATA, 5'd3, 32'h1234_5678);
        send_item(CMD_FINISH, 5'd0, 32'h0);
        send_item(CMD_DATA, 5'd31, 32'h8000_0001);
        send_checksum(5'd31, 1'b1);
        send_item(CMD_DATA, 5'd0, 32'h1234_5678);
        send_checksum(5'd0, 1'b0);
        send_item(CMD_FINISH, 5'd16, 32'h0);
        w = $urandom();
        send_item(CMD_DATA, 5'd7, w);
        send_checksum(5'd7, 1'b1);
        send_item(CMD_READ, 5'd7, 32'h0);
        send_item(CMD_DATA, 5'd12, 32'h0);
        send_checksum(5'd12, 1'b1);
        send_checksum(5'd12, 1'b0);
        send_item(CMD_FINISH, 5'd0, 32'h0);

        // Random part, with a stretch free of idling and one long hold-off.
        while (items_sent < ITEM_TARGET) begin
            no_idle = (items_sent >= 150 && items_sent < 250);
            if (!hold_req && items_sent >= 280) begin
                hold_req = 1'b1;
                repeat (12) begin
                    send_item(CMD_READ, CAND_W'($urandom_range(NUM_CAND - 1)), $urandom());
                end
            end
            if ($urandom_range(99) < 70) begin
                send_batch();
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    send_item(t_cmd'($urandom_range(3)),
                              CAND_W'($urandom_range(NUM_CAND - 1)), $urandom());
                end
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input beats sent, %0d result beats checked, %0d mismatches",
                 items_sent, sb.checked, sb.err_count);
        $display("%0d finishes reported a match, %0d candidate reads",
                 sb.match_reports, sb.read_reports);
        if (sb.err_count == 0) begin
            $display("tb_crc32c_list_checker passed");
        end else begin
            $display("tb_crc32c_list_checker failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ccl_pkg.sv
src/ccl_front.sv
src/ccl_queue.sv
src/ccl_back.sv
src/crc32c_list_checker.sv
tb/tb_crc32c_list_checker.sv
